### hw/rtl/lwa_pkg.sv
// Shared types and constants of the Lax-Wendroff advection step unit.
package lwa_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int INDEX_W    = 10;
    localparam int COURANT_W  = 16;
    localparam int GRID_W     = 11;
    localparam int HALF_C2_W  = 18;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COURANT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 1'b1;

    localparam logic signed [COURANT_W-1:0] COURANT_RESET = 16'sd8192;
    localparam logic [GRID_W-1:0]           GRID_RESET    = 11'd1024;
    localparam logic [HALF_C2_W-1:0]        HALF_C2_RESET = 18'd2048;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [INDEX_W-1:0]         t_index;

    typedef struct packed {
        logic signed [COURANT_W-1:0] courant;
        logic [HALF_C2_W-1:0]        half_c2;
        logic [GRID_W-1:0]           grid_size;
    } t_cfg;

    typedef struct packed {
        t_sample fm;
        t_sample f;
        t_sample fp;
        t_index  idx;
        logic    last;
    } t_job;

    typedef enum logic [1:0] {
        ST_STREAM,
        ST_EDGE,
        ST_WRAP
    } t_tail_state;

endpackage

### hw/rtl/lwa_if.sv
// Stream interfaces for grid samples in and updated points out.
interface lwa_in_if;
    import lwa_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface lwa_out_if;
    import lwa_pkg::*;
    logic    valid;
    logic    ready;
    t_sample new_value;
    t_index  point_index;
    logic    last;
    modport source (output valid, output new_value, output point_index, output last,
                    input ready);
    modport sink (input valid, input new_value, input point_index, input last,
                  output ready);
endinterface

### hw/rtl/lwa_cfg.sv
// Configuration registers and the derived half courant squared term.
module lwa_cfg
    import lwa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic signed [COURANT_W-1:0] r_courant;
    logic [HALF_C2_W-1:0]        r_half_c2;
    logic [GRID_W-1:0]           r_grid_size;
    logic signed [COURANT_W-1:0] wr_courant;
    logic signed [2*COURANT_W-1:0] c_sq;
    logic [2*COURANT_W:0]        c_sq_rnd;
    logic [HALF_C2_W-1:0]        n_half_c2;

    always_comb begin
        wr_courant = $signed(i_cfg_data[COURANT_W-1:0]);
        c_sq       = wr_courant * wr_courant;
        c_sq_rnd   = {1'b0, $unsigned(c_sq)} + (33'd1 << 14);
        n_half_c2  = c_sq_rnd[15 +: HALF_C2_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_courant   <= COURANT_RESET;
            r_half_c2   <= HALF_C2_RESET;
            r_grid_size <= GRID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COURANT: begin
                    r_courant <= wr_courant;
                    r_half_c2 <= n_half_c2;
                end
                CFG_GRID_SIZE: begin
                    r_grid_size <= i_cfg_data[GRID_W-1:0];
                end
                default: begin
                    r_courant <= r_courant;
                end
            endcase
        end
    end

    assign o_cfg.courant   = r_courant;
    assign o_cfg.half_c2   = r_half_c2;
    assign o_cfg.grid_size = r_grid_size;

endmodule

### hw/rtl/lwa_window.sv
// Neighbor window, arrival counter and job issue for each grid point.
module lwa_window
    import lwa_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    lwa_in_if.sink i_in,
    output t_job   o_job,
    output logic   o_job_valid,
    input  logic   i_job_ready
);

    localparam int CNT_W = $clog2(MAX_POINTS);
    localparam int NW    = (CNT_W + 1 > GRID_W) ? CNT_W + 1 : GRID_W;
    localparam int WW    = NW + INDEX_W;

    t_tail_state      r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_job_valid, n_job_valid;
    t_job             r_job, n_job;
    t_sample          r_first, n_first;
    t_sample          r_second, n_second;
    t_sample          r_older, n_older;
    t_sample          r_newer, n_newer;
    t_sample          r_last_s, n_last_s;
    t_index           r_last_idx, n_last_idx;

    logic [NW-1:0] grid_ext;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] k_ext;
    logic [WW-1:0] idx_prev_w;
    logic [WW-1:0] idx_cur_w;
    logic          is_last;
    logic          slot_free;
    logic          accept;

    always_comb begin
        grid_ext = NW'(i_cfg.grid_size);
        if (grid_ext < NW'(3)) begin
            n_eff = NW'(3);
        end else if (grid_ext > NW'(MAX_POINTS)) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = grid_ext;
        end
        k_ext      = NW'(r_count);
        is_last    = (k_ext >= n_eff - NW'(1));
        idx_prev_w = WW'(k_ext - NW'(1));
        idx_cur_w  = WW'(k_ext);
    end

    assign slot_free   = !r_job_valid || i_job_ready;
    assign i_in.ready  = slot_free && (r_state == ST_STREAM);
    assign accept      = i_in.valid && i_in.ready;
    assign o_job       = r_job;
    assign o_job_valid = r_job_valid;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_job_valid = r_job_valid && !i_job_ready;
        n_job       = r_job;
        n_first     = r_first;
        n_second    = r_second;
        n_older     = r_older;
        n_newer     = r_newer;
        n_last_s    = r_last_s;
        n_last_idx  = r_last_idx;
        case (r_state)
            ST_EDGE: begin
                if (slot_free) begin
                    n_job_valid = 1'b1;
                    n_job.fm    = r_newer;
                    n_job.f     = r_last_s;
                    n_job.fp    = r_first;
                    n_job.idx   = r_last_idx;
                    n_job.last  = 1'b0;
                    n_state     = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (slot_free) begin
                    n_job_valid = 1'b1;
                    n_job.fm    = r_last_s;
                    n_job.f     = r_first;
                    n_job.fp    = r_second;
                    n_job.idx   = '0;
                    n_job.last  = 1'b1;
                    n_state     = ST_STREAM;
                end
            end
            default: begin
                if (accept) begin
                    if (r_count == CNT_W'(0)) begin
                        n_first = i_in.sample;
                        n_newer = i_in.sample;
                        n_count = CNT_W'(1);
                    end else if (r_count == CNT_W'(1)) begin
                        n_second = i_in.sample;
                        n_older  = r_newer;
                        n_newer  = i_in.sample;
                        n_count  = CNT_W'(2);
                    end else begin
                        n_job_valid = 1'b1;
                        n_job.fm    = r_older;
                        n_job.f     = r_newer;
                        n_job.fp    = i_in.sample;
                        n_job.idx   = idx_prev_w[INDEX_W-1:0];
                        n_job.last  = 1'b0;
                        if (is_last) begin
                            n_last_s   = i_in.sample;
                            n_last_idx = idx_cur_w[INDEX_W-1:0];
                            n_count    = '0;
                            n_state    = ST_EDGE;
                        end else begin
                            n_older = r_newer;
                            n_newer = i_in.sample;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_STREAM;
            r_count     <= '0;
            r_job_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_job_valid <= n_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_first    <= n_first;
        r_second   <= n_second;
        r_older    <= n_older;
        r_newer    <= n_newer;
        r_last_s   <= n_last_s;
        r_last_idx <= n_last_idx;
    end

`ifndef ASSERT_OFF
    a_last_sample_opens_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_count > CNT_W'(1)) && is_last |=> (r_state == ST_EDGE) && r_job_valid)
        else $error("last sample did not start the boundary points");
    a_tail_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_STREAM) |-> !i_in.ready)
        else $error("input taken while boundary points are pending");
    a_wrap_point_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && r_job.last |-> (r_job.idx == '0))
        else $error("final point of a step has a nonzero index");
`endif

endmodule

### hw/rtl/lwa_calc.sv
// Two-stage datapath: products, then rounding, sum and saturation into the result register.
module lwa_calc
    import lwa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_job       i_job,
    input  logic       i_job_valid,
    output logic       o_job_ready,
    lwa_out_if.source  o_out
);

    localparam int P1W  = COURANT_W + SAMPLE_W + 1;
    localparam int P2W  = HALF_C2_W + 1 + SAMPLE_W + 2;
    localparam int SUMW = SAMPLE_W + 10;

    logic                   r_v2;
    logic                   r_v3;
    logic signed [P1W-1:0]  r_p1;
    logic signed [P2W-1:0]  r_p2;
    t_sample                r_f2;
    t_index                 r_idx2;
    logic                   r_last2;
    t_sample                r_value;
    t_index                 r_idx3;
    logic                   r_last3;

    logic                   rdy2;
    logic                   rdy3;
    logic signed [SAMPLE_W:0]      d1;
    logic signed [SAMPLE_W+1:0]    d2;
    logic signed [HALF_C2_W:0]     hc2_s;
    logic signed [P1W-1:0]         n_p1;
    logic signed [P2W-1:0]         n_p2;
    logic signed [P1W:0]           b1;
    logic signed [P2W:0]           b2;
    logic signed [SUMW-1:0]        sum;
    t_sample                       n_value;

    assign rdy3        = !r_v3 || o_out.ready;
    assign rdy2        = !r_v2 || rdy3;
    assign o_job_ready = rdy2;

    always_comb begin
        d1    = (SAMPLE_W+1)'(i_job.fp) - (SAMPLE_W+1)'(i_job.fm);
        d2    = (SAMPLE_W+2)'(i_job.fp) - ((SAMPLE_W+2)'(i_job.f) <<< 1)
              + (SAMPLE_W+2)'(i_job.fm);
        hc2_s = $signed({1'b0, i_cfg.half_c2});
        n_p1  = i_cfg.courant * d1;
        n_p2  = hc2_s * d2;
    end

    always_comb begin
        b1  = (P1W+1)'(r_p1) + (P1W+1)'(1 << 14);
        b2  = (P2W+1)'(r_p2) + (P2W+1)'(1 << 13);
        sum = SUMW'(r_f2) - SUMW'(b1 >>> 15) + SUMW'(b2 >>> 14);
        if (sum > SUMW'(8388607)) begin
            n_value = 24'sh7FFFFF;
        end else if (sum < -SUMW'(8388608)) begin
            n_value = 24'sh800000;
        end else begin
            n_value = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_job_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_job_valid) begin
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_f2    <= i_job.f;
            r_idx2  <= i_job.idx;
            r_last2 <= i_job.last;
        end
        if (rdy3 && r_v2) begin
            r_value <= n_value;
            r_idx3  <= r_idx2;
            r_last3 <= r_last2;
        end
    end

    assign o_out.valid       = r_v3;
    assign o_out.new_value   = r_value;
    assign o_out.point_index = r_idx3;
    assign o_out.last        = r_last3;

`ifndef ASSERT_OFF
    a_stage_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && rdy3 |=> r_v3)
        else $error("product stage lost an item");
    a_stall_keeps_products: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !rdy2 |=> r_v2 && $stable(r_p1) && $stable(r_p2))
        else $error("stalled products changed");
`endif

endmodule

### hw/rtl/lax_wendroff_advection_step_unit.sv
// Top level of the Lax-Wendroff advection step unit.
// Usage: grid samples of the old field (signed Q8.16) enter on i_in, one per
// transfer, in index order 0 to N-1, where N is the grid_size register clamped
// to [3, MAX_POINTS]. Samples 0 and 1 give no result; sample i gives point i-1,
// and the last sample gives points N-2, N-1 and 0, the last one flagged by last.
// Each result on o_out carries new_value and point_index.
// Path: the window registers the job of each transferred sample, the datapath
// registers its products, and the result register then drives o_out.
// Throughput is one sample per cycle while o_out.ready stays high; after the last
// sample of a step, i_in.ready stays low while the two boundary points go to the datapath.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 is the
// courant number, signed Q2.14; 1 is the grid size); write only while idle.
// Reset (synchronous, active low) empties the pipeline, restarts the step at
// index 0 and loads courant 0.5 and grid size 1024.
// When the receiver holds o_out.ready low, the result register holds and the
// two pipeline stages behind it still fill before i_in.ready drops.
module lax_wendroff_advection_step_unit
    import lwa_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lwa_in_if.sink                i_in,
    lwa_out_if.source             o_out
);

    t_cfg cfg;
    t_job job;
    logic job_valid;
    logic job_ready;

    lwa_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lwa_window #(
        .MAX_POINTS (MAX_POINTS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready)
    );

    lwa_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .o_out       (o_out)
    );

endmodule
